/* rtl/bpd_pkg.sv */
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types and codes of the bitmap row pixel decoder: format codes,
// register indexes, channel payloads and the internal pixel token.
// ----------------------------------------------------------------------------
package bpd_pkg;

   // pixel format codes
   localparam logic [2:0] FMT_1BPP  = 3'd0;
   localparam logic [2:0] FMT_4BPP  = 3'd1;
   localparam logic [2:0] FMT_8BPP  = 3'd2;
   localparam logic [2:0] FMT_16BPP = 3'd3;
   localparam logic [2:0] FMT_24BPP = 3'd4;
   localparam logic [2:0] FMT_32BPP = 3'd5;

   // register indexes
   localparam logic CSR_PIXEL_FORMAT = 1'b0;
   localparam logic CSR_IMAGE_WIDTH  = 1'b1;
   localparam int   CSR_DATA_W       = 13;

   // commands
   localparam logic CMD_PIXEL   = 1'b0;
   localparam logic CMD_PALETTE = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic [7:0] palette_index;
      logic [7:0] palette_red;
      logic [7:0] palette_green;
      logic [7:0] palette_blue;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] column;
      logic        row_end;
      logic        last;
   } rsp_payload_type;

   // one pixel on its way to the palette stage
   typedef struct packed {
      logic        pal;     // look up idx, else use rgb as is
      logic [7:0]  idx;
      logic [23:0] rgb;
      logic [11:0] column;
      logic        row_end;
      logic        last;
   } pixel_token_type;

   typedef struct packed {
      logic        en;
      logic [7:0]  idx;
      logic [23:0] rgb;
   } palette_write_type;

endpackage

/* rtl/bpd_chan_if.sv */
// ----------------------------------------------------------------------------
// bpd_chan_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface bpd_chan_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/bpd_unpack.sv */
// ----------------------------------------------------------------------------
// bpd_unpack
// Holds the current pixel-array byte and the row state; splits it into pixel
// tokens, one per cycle when tok_ready allows, and forwards palette writes.
// ----------------------------------------------------------------------------
module bpd_unpack
   import bpd_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   bpd_chan_if.sink          req,
   input  logic [2:0]        pixel_format,
   input  logic [12:0]       image_width,
   output pixel_token_type   tok,
   output logic              tok_valid,
   input  logic              tok_ready,
   output palette_write_type pal_wr
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > 14) ? CW + 1 : 14;

   logic          cur_valid_ff, cur_valid_in;
   logic [7:0]    cur_byte_ff, cur_byte_in;
   logic [2:0]    sub_ff, sub_in;
   logic [CW-1:0] col_ff, col_in, col_nx;
   logic [1:0]    phase_ff, phase_in, phase_nx;
   logic [23:0]   held_ff, held_in, held_nx;
   logic [1:0]    mod4_ff, mod4_in, mod4_nx, mod4_cur;
   logic          pad_ff, pad_in, pad_nx;

   logic [EW-1:0] width_ext, eff_w;
   logic          col_end, fmt_ok, first, done, emit, step_en, accept;
   logic [1:0]    last_phase;
   logic [23:0]   direct_rgb;
   logic [15:0]   word16;

   // clamp width into 1..MAX_WIDTH
   always_comb begin
      width_ext = EW'(image_width);
      eff_w     = width_ext;
      if (width_ext == '0) begin
         eff_w = EW'(1);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end
   end

   assign col_end = (EW'(col_ff) + EW'(1)) >= eff_w;
   assign fmt_ok  = pixel_format <= FMT_32BPP;
   assign first   = sub_ff == 3'd0;
   assign mod4_cur = first ? mod4_ff + 2'd1 : mod4_ff;

   always_comb begin
      case (pixel_format)
         FMT_16BPP: last_phase = 2'd1;
         FMT_24BPP: last_phase = 2'd2;
         default:   last_phase = 2'd3;
      endcase
   end

   // multi-byte pixels: 5-5-5 little endian or blue-green-red
   assign word16 = {cur_byte_ff, held_ff[7:0]};
   always_comb begin
      case (pixel_format)
         FMT_16BPP:
            direct_rgb = {word16[14:10], 3'd0, word16[9:5], 3'd0, word16[4:0], 3'd0};
         FMT_24BPP:
            direct_rgb = {cur_byte_ff, held_ff[15:8], held_ff[7:0]};
         default:
            direct_rgb = {held_ff[23:16], held_ff[15:8], held_ff[7:0]};
      endcase
   end

   always_comb begin
      tok       = '0;
      emit      = 1'b0;
      done      = 1'b1;
      col_nx    = col_ff;
      phase_nx  = phase_ff;
      held_nx   = held_ff;
      mod4_nx   = mod4_ff;
      pad_nx    = pad_ff;
      if (cur_valid_ff && fmt_ok) begin
         mod4_nx = mod4_cur;
         if (first && pad_ff) begin
            pad_nx = mod4_cur != 2'd0;
         end else begin
            case (pixel_format)
               FMT_1BPP: begin
                  emit    = 1'b1;
                  tok.pal = 1'b1;
                  tok.idx = {7'd0, cur_byte_ff[3'd7 - sub_ff]};
                  done    = col_end || (sub_ff == 3'd7);
               end
               FMT_4BPP: begin
                  emit    = 1'b1;
                  tok.pal = 1'b1;
                  tok.idx = sub_ff[0] ? {4'd0, cur_byte_ff[3:0]} : {4'd0, cur_byte_ff[7:4]};
                  done    = col_end || sub_ff[0];
               end
               FMT_8BPP: begin
                  emit    = 1'b1;
                  tok.pal = 1'b1;
                  tok.idx = cur_byte_ff;
               end
               default: begin
                  if (phase_ff >= last_phase) begin
                     emit     = 1'b1;
                     tok.rgb  = direct_rgb;
                     phase_nx = 2'd0;
                     held_nx  = '0;
                  end else begin
                     case (phase_ff)
                        2'd0:    held_nx[7:0]   = cur_byte_ff;
                        2'd1:    held_nx[15:8]  = cur_byte_ff;
                        2'd2:    held_nx[23:16] = cur_byte_ff;
                        default: held_nx        = held_ff;
                     endcase
                     phase_nx = phase_ff + 2'd1;
                  end
               end
            endcase
            if (emit) begin
               tok.column  = 12'(col_ff);
               tok.row_end = col_end;
               tok.last    = done;
               if (col_end) begin
                  col_nx   = '0;
                  phase_nx = 2'd0;
                  held_nx  = '0;
                  pad_nx   = mod4_cur != 2'd0;
               end else begin
                  col_nx = col_ff + CW'(1);
               end
            end
         end
      end
   end

   assign tok_valid = emit;
   assign step_en   = cur_valid_ff && (!emit || tok_ready);
   assign req.ready = !cur_valid_ff || (step_en && done);
   assign accept    = req.valid && req.ready;

   assign pal_wr.en  = accept && (req.payload.command == CMD_PALETTE);
   assign pal_wr.idx = req.payload.palette_index;
   assign pal_wr.rgb = {req.payload.palette_red, req.payload.palette_green,
                        req.payload.palette_blue};

   always_comb begin
      col_in   = step_en ? col_nx   : col_ff;
      phase_in = step_en ? phase_nx : phase_ff;
      held_in  = step_en ? held_nx  : held_ff;
      mod4_in  = step_en ? mod4_nx  : mod4_ff;
      pad_in   = step_en ? pad_nx   : pad_ff;

      cur_valid_in = cur_valid_ff;
      cur_byte_in  = cur_byte_ff;
      sub_in       = sub_ff;
      if (step_en) begin
         if (done) begin
            cur_valid_in = 1'b0;
            sub_in       = 3'd0;
         end else begin
            sub_in = sub_ff + 3'd1;
         end
      end
      if (accept && (req.payload.command == CMD_PIXEL)) begin
         cur_valid_in = 1'b1;
         cur_byte_in  = req.payload.data_byte;
         sub_in       = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         sub_ff       <= '0;
         col_ff       <= '0;
         phase_ff     <= '0;
         held_ff      <= '0;
         mod4_ff      <= '0;
         pad_ff       <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         sub_ff       <= sub_in;
         col_ff       <= col_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         mod4_ff      <= mod4_in;
         pad_ff       <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_byte_ff <= cur_byte_in;
   end

endmodule

/* rtl/bpd_palette.sv */
// ----------------------------------------------------------------------------
// bpd_palette
// Palette memory with a registered read; the token stage that waits on the
// read data sits here too.
// ----------------------------------------------------------------------------
module bpd_palette
   import bpd_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  palette_write_type pal_wr,
   input  pixel_token_type   tok,
   input  logic              tok_valid,
   output logic              tok_ready,
   output rsp_payload_type   pix,
   output logic              pix_valid,
   input  logic              pix_ready
);
   localparam int         PW          = $clog2(PALETTE_DEPTH);
   localparam logic [8:0] DEPTH_LIMIT = 9'(PALETTE_DEPTH);

   logic [23:0]     mem [PALETTE_DEPTH];
   logic [23:0]     rdata_ff;
   logic            s1_valid_ff, s1_valid_in;
   pixel_token_type s1_tok_ff;
   logic            s1_oob_ff;
   logic            load, wr_ok;
   logic [23:0]     rgb;

   assign wr_ok     = {1'b0, pal_wr.idx} < DEPTH_LIMIT;
   assign tok_ready = !s1_valid_ff || pix_ready;
   assign load      = tok_valid && tok_ready;
   assign s1_valid_in = load || (s1_valid_ff && !pix_ready);

   // a read and a write of one entry in the same cycle returns the old
   // entry, which is what the earlier pixel must see
   always_ff @(posedge clock) begin
      if (pal_wr.en && wr_ok) begin
         mem[pal_wr.idx[PW-1:0]] <= pal_wr.rgb;
      end
      if (load) begin
         rdata_ff <= mem[tok.idx[PW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_tok_ff <= tok;
         s1_oob_ff <= !({1'b0, tok.idx} < DEPTH_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_comb begin
      if (!s1_tok_ff.pal) begin
         rgb = s1_tok_ff.rgb;
      end else if (s1_oob_ff) begin
         rgb = '0;
      end else begin
         rgb = rdata_ff;
      end
   end

   assign pix_valid   = s1_valid_ff;
   assign pix.red     = rgb[23:16];
   assign pix.green   = rgb[15:8];
   assign pix.blue    = rgb[7:0];
   assign pix.column  = s1_tok_ff.column;
   assign pix.row_end = s1_tok_ff.row_end;
   assign pix.last    = s1_tok_ff.last;

endmodule

/* rtl/bpd_out.sv */
// ----------------------------------------------------------------------------
// bpd_out
// Output register: holds a finished pixel until the sink takes the beat.
// ----------------------------------------------------------------------------
module bpd_out
   import bpd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  rsp_payload_type pix,
   input  logic            pix_valid,
   output logic            pix_ready,
   bpd_chan_if.source      rsp
);
   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   assign pix_ready = !valid_ff || rsp.ready;
   assign valid_in  = pix_ready ? pix_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_ready && pix_valid) begin
         data_ff <= pix;
      end
   end

   assign rsp.valid   = valid_ff;
   assign rsp.payload = data_ff;

endmodule

/* rtl/bmp_row_pixel_decoder.sv */
// ----------------------------------------------------------------------------
// bmp_row_pixel_decoder
// Decodes the padded pixel-array bytes of an uncompressed bitmap into RGB888
// pixels with their column and row-end marks.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Beat                               Accepted when
//   req      in   pixel byte or palette entry write  req.valid & req.ready
//   rsp      out  one RGB888 pixel                   rsp.valid & rsp.ready
//   csr      in   register write (index, data)       csr_write_enable
//
// Bytes of 8, 16, 24 or 32 bpp stream back to back; a 4 bpp byte yields up to
// 2 pixels and a 1 bpp byte up to 8, one pixel per cycle through the single
// palette read port, as long as rsp is not stalled. A byte reaches rsp through
// the byte register, the palette read register and the output register.
// Reset (synchronous) clears the row state and the pipeline valids; the
// palette memory is not cleared and must be written before it is used.
// A stalled rsp holds the output register; the stall then backs up through
// the palette stage into the byte register and finally drops req.ready.
// ----------------------------------------------------------------------------
module bmp_row_pixel_decoder
   import bpd_pkg::*;
#(
   parameter int MAX_WIDTH     = 4096,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   bpd_chan_if.sink              req,
   bpd_chan_if.source            rsp,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);
   // configuration registers
   logic [2:0]  pixel_format_ff, pixel_format_in;
   logic [12:0] image_width_ff, image_width_in;

   // unpacker to palette stage
   pixel_token_type   tok;
   logic              tok_valid, tok_ready;
   palette_write_type pal_wr;

   // palette stage to output register
   rsp_payload_type pix;
   logic            pix_valid, pix_ready;

   // decode a register write; the user must write only while the block is idle, the block does not enforce it
   always_comb begin
      pixel_format_in = pixel_format_ff;
      image_width_in  = image_width_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PIXEL_FORMAT: pixel_format_in = csr_write_data[2:0];
            CSR_IMAGE_WIDTH:  image_width_in  = csr_write_data[12:0];
            default: begin
               pixel_format_in = pixel_format_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_8BPP;
         image_width_ff  <= 13'd1;
      end else begin
         pixel_format_ff <= pixel_format_in;
         image_width_ff  <= image_width_in;
      end
   end

   // split bytes into pixel tokens and track row position and padding
   bpd_unpack #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_unpack (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .pixel_format (pixel_format_ff),
      .image_width  (image_width_ff),
      .tok          (tok),
      .tok_valid    (tok_valid),
      .tok_ready    (tok_ready),
      .pal_wr       (pal_wr)
   );

   // look up indexed pixels; direct pixels pass alongside
   bpd_palette #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock     (clock),
      .reset     (reset),
      .pal_wr    (pal_wr),
      .tok       (tok),
      .tok_valid (tok_valid),
      .tok_ready (tok_ready),
      .pix       (pix),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready)
   );

   // hold the finished beat for the sink
   bpd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .pix       (pix),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .rsp       (rsp)
   );

endmodule
